### design/crq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crq_pkg
// shared types and constants for the command ring queue
// ----------------------------------------------------------------------------
package crq_pkg;

  localparam int QUEUE_SIZE = 16;
  localparam int PTR_W      = (QUEUE_SIZE > 1) ? $clog2(QUEUE_SIZE) : 1;

  // request codes
  localparam logic [1:0] REQ_PUSH  = 2'd0;
  localparam logic [1:0] REQ_POP   = 2'd1;
  localparam logic [1:0] REQ_BATCH = 2'd2;
  localparam logic [1:0] REQ_NONE  = 2'd3;

  // source codes
  localparam logic [1:0] SRC_BUTTON = 2'd0;
  localparam logic [1:0] SRC_MQTT   = 2'd1;
  localparam logic [1:0] SRC_WEB    = 2'd2;
  localparam logic [1:0] SRC_OTHER  = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  cmd_kind;
    logic [31:0] cmd_value;
    logic [1:0]  cmd_source;
    logic        batch_first;
    logic [7:0]  batch_count;
  } req_item_t;

  typedef struct packed {
    logic        accepted;
    logic        pop_valid;
    logic [7:0]  pop_kind;
    logic [31:0] pop_value;
    logic [1:0]  pop_source;
    logic [3:0]  free_slots;
    logic [31:0] drops_button;
    logic [31:0] drops_mqtt;
    logic [31:0] drops_web;
  } rsp_item_t;

  // one stored command
  typedef struct packed {
    logic [7:0]  kind;
    logic [31:0] value;
    logic [1:0]  source;
  } entry_t;

  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t entry;
  } ring_ctrl_t;

  typedef struct packed {
    logic             full;
    logic             empty;
    logic [PTR_W-1:0] free;
  } ring_stat_t;

endpackage

### design/crq_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crq_ring
// ring storage with read and write pointers, one slot kept empty
// ----------------------------------------------------------------------------
module crq_ring (
  input  logic                clk,
  input  logic                rst,
  input  crq_pkg::ring_ctrl_t ctrl,
  output crq_pkg::ring_stat_t stat,
  output crq_pkg::entry_t     rd_entry
);
  import crq_pkg::*;

  entry_t           mem [QUEUE_SIZE];
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr_next;
  logic [PTR_W-1:0] wr_ptr_next;
  logic [PTR_W:0]   used;

  assign rd_ptr_next = (rd_ptr == PTR_W'(QUEUE_SIZE - 1)) ? '0 : rd_ptr + 1'b1;
  assign wr_ptr_next = (wr_ptr == PTR_W'(QUEUE_SIZE - 1)) ? '0 : wr_ptr + 1'b1;

  always_comb begin
    if (wr_ptr >= rd_ptr) begin
      used = {1'b0, wr_ptr} - {1'b0, rd_ptr};
    end else begin
      used = {1'b0, wr_ptr} + (PTR_W+1)'(QUEUE_SIZE) - {1'b0, rd_ptr};
    end
  end

  assign stat.full  = (wr_ptr_next == rd_ptr);
  assign stat.empty = (wr_ptr == rd_ptr);
  assign stat.free  = PTR_W'((PTR_W+1)'(QUEUE_SIZE - 1) - used);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
    end else begin
      if (ctrl.push) begin
        wr_ptr <= wr_ptr_next;
      end
      if (ctrl.pop) begin
        rd_ptr <= rd_ptr_next;
      end
    end
  end

  // storage and registered read port
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[wr_ptr] <= ctrl.entry;
    end
    if (ctrl.pop) begin
      rd_entry <= mem[rd_ptr];
    end
  end

endmodule

### design/command_ring_queue_with_drop_counts.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_ring_queue_with_drop_counts
// command fifo with batch admission and per-source drop counters
// ----------------------------------------------------------------------------
// usage
//   req channel: one beat is a push, a pop or one element of a batch push;
//   the first batch element carries the length and the whole batch is
//   admitted only if it fits in the free slots at that moment
//   rsp channel: exactly one beat per request beat, in order, giving the
//   accept flag, the popped command, free slots and the three drop counters
//   the ring holds QUEUE_SIZE - 1 commands; a refused push from button,
//   mqtt or web bumps that source's wrapping 32-bit counter
// timing
//   the rsp beat is registered and appears in the cycle after its req beat
//   is taken; one request per cycle is taken while req_ready is high, set by
//   the single pointer update and one storage read/write per beat
// reset
//   synchronous rst empties the ring, ends any batch and clears counters;
//   storage contents are not cleared
// back-pressure
//   the rsp register holds its beat while rsp_ready is low; req_ready
//   drops only while a beat waits and rsp_ready is low
// ----------------------------------------------------------------------------
module command_ring_queue_with_drop_counts (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  crq_pkg::req_item_t req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output crq_pkg::rsp_item_t rsp
);
  import crq_pkg::*;

  localparam int CMP_W = PTR_W + 8;

  ring_ctrl_t  ring_ctrl;
  ring_stat_t  ring_stat;
  entry_t      rd_entry;

  logic        fire;
  logic        is_push;
  logic        is_pop;
  logic        is_batch;

  // batch tracking
  logic [7:0]  batch_left;
  logic        batch_admitted;
  logic [7:0]  batch_left_next;
  logic        batch_admitted_next;
  logic [7:0]  left_eff;
  logic        adm_eff;
  logic        live;

  logic        push_req;
  logic        push_ok;
  logic        pop_ok;
  logic        drop;

  // drop counters
  logic [31:0] drops_button;
  logic [31:0] drops_mqtt;
  logic [31:0] drops_web;

  // result register
  logic        accepted;
  logic        pop_valid;
  logic [PTR_W+3:0] free_wide;

  assign fire      = req_valid && req_ready;
  assign req_ready = !rsp_valid || rsp_ready;

  assign is_push  = (req.req_type == REQ_PUSH);
  assign is_pop   = (req.req_type == REQ_POP);
  assign is_batch = (req.req_type == REQ_BATCH);

  // batch admission decision
  always_comb begin
    left_eff            = batch_left;
    adm_eff             = batch_admitted;
    live                = 1'b0;
    batch_left_next     = batch_left;
    batch_admitted_next = batch_admitted;
    if (req.batch_first) begin
      if (req.batch_count == 8'd0) begin
        // empty batch ends whatever was in progress
        batch_left_next     = 8'd0;
        batch_admitted_next = 1'b0;
      end else begin
        left_eff = req.batch_count;
        adm_eff  = (CMP_W'(req.batch_count) <= CMP_W'(ring_stat.free));
        live     = 1'b1;
      end
    end else begin
      live = (batch_left != 8'd0);
    end
    if (live) begin
      batch_left_next     = left_eff - 8'd1;
      batch_admitted_next = (batch_left_next == 8'd0) ? 1'b0 : adm_eff;
    end
  end

  assign push_req = is_push || (is_batch && live && adm_eff);
  assign push_ok  = fire && push_req && !ring_stat.full;
  assign pop_ok   = fire && is_pop && !ring_stat.empty;
  // refused: full ring on any store, or any element of a refused batch
  assign drop     = fire && ((push_req && ring_stat.full) || (is_batch && live && !adm_eff));

  assign ring_ctrl.push         = push_ok;
  assign ring_ctrl.pop          = pop_ok;
  assign ring_ctrl.entry.kind   = req.cmd_kind;
  assign ring_ctrl.entry.value  = req.cmd_value;
  assign ring_ctrl.entry.source = req.cmd_source;

  crq_ring u_ring (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ring_ctrl),
    .stat     (ring_stat),
    .rd_entry (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      batch_left     <= 8'd0;
      batch_admitted <= 1'b0;
      drops_button   <= '0;
      drops_mqtt     <= '0;
      drops_web      <= '0;
      rsp_valid      <= 1'b0;
      accepted       <= 1'b0;
      pop_valid      <= 1'b0;
    end else begin
      if (fire && is_batch) begin
        batch_left     <= batch_left_next;
        batch_admitted <= batch_admitted_next;
      end
      if (drop) begin
        unique case (req.cmd_source)
          SRC_BUTTON: drops_button <= drops_button + 32'd1;
          SRC_MQTT:   drops_mqtt   <= drops_mqtt + 32'd1;
          SRC_WEB:    drops_web    <= drops_web + 32'd1;
          SRC_OTHER:  ;  // never counted
          default:    ;
        endcase
      end
      if (fire) begin
        rsp_valid <= 1'b1;
        accepted  <= push_ok;
        pop_valid <= pop_ok;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // state only moves on a request beat, so the live pointers and counters
  // are the after-step values of the beat being shown
  assign free_wide = {4'b0000, ring_stat.free};

  assign rsp.accepted     = accepted;
  assign rsp.pop_valid    = pop_valid;
  assign rsp.pop_kind     = pop_valid ? rd_entry.kind : 8'd0;
  assign rsp.pop_value    = pop_valid ? rd_entry.value : 32'd0;
  assign rsp.pop_source   = pop_valid ? rd_entry.source : 2'd0;
  assign rsp.free_slots   = free_wide[3:0];
  assign rsp.drops_button = drops_button;
  assign rsp.drops_mqtt   = drops_mqtt;
  assign rsp.drops_web    = drops_web;

endmodule

### sim/command_ring_queue_with_drop_counts_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_ring_queue_with_drop_counts_test
// self-checking bench: random valid/ready traffic against a ring queue model
// ----------------------------------------------------------------------------
// a short directed run covers empty pops, field extremes, the unused request
// code, stray and empty batches, refused and abandoned batches; then about
// 550 random beats alternate between fill-biased and drain-biased stretches
// of pushes, pops, batches (some abandoned or overrun, some sized to exactly
// the free room with pushes and pops slipped in between) and noise
// every accepted request beat is run through a ring queue model in the
// scoreboard; every response beat is checked field by field in order
// ----------------------------------------------------------------------------
module command_ring_queue_with_drop_counts_test;
  import crq_pkg::*;

  localparam int STALL_LIMIT  = 2000;  // cycles with no beat on either side
  localparam int HOLD_CYCLES  = 100;   // long receiver hold-off
  localparam int RANDOM_BEATS = 550;

  // --------------------------------------------------------------------------
  // scoreboard: ring queue model plus the responses it predicts
  // --------------------------------------------------------------------------
  class ring_queue_scoreboard;
    entry_t      slots [QUEUE_SIZE];
    int unsigned rd_idx;
    int unsigned wr_idx;
    logic [7:0]  batch_left;
    bit          batch_ok;
    logic [31:0] drop_button;
    logic [31:0] drop_mqtt;
    logic [31:0] drop_web;
    rsp_item_t   awaited_rsp [$];
    int          errors;

    function new();
      rd_idx      = 0;
      wr_idx      = 0;
      batch_left  = '0;
      batch_ok    = 1'b0;
      drop_button = '0;
      drop_mqtt   = '0;
      drop_web    = '0;
      errors      = 0;
    endfunction

    function int unsigned pending();
      return awaited_rsp.size();
    endfunction

    function int unsigned free_room();
      int unsigned used;
      used = (wr_idx + QUEUE_SIZE - rd_idx) % QUEUE_SIZE;
      return (QUEUE_SIZE - 1) - used;
    endfunction

    function void count_drop(logic [1:0] src);
      case (src)
        SRC_BUTTON: drop_button = drop_button + 32'd1;
        SRC_MQTT:   drop_mqtt   = drop_mqtt + 32'd1;
        SRC_WEB:    drop_web    = drop_web + 32'd1;
        default:    ;  // other source is never counted
      endcase
    endfunction

    // stores one command, or counts a drop when the ring is full
    function bit store_cmd(entry_t e);
      if ((wr_idx + 1) % QUEUE_SIZE == rd_idx) begin
        count_drop(e.source);
        return 1'b0;
      end
      slots[wr_idx] = e;
      wr_idx = (wr_idx + 1) % QUEUE_SIZE;
      return 1'b1;
    endfunction

    // advances the model by one accepted request beat
    function void note_request(req_item_t r);
      rsp_item_t exp_rsp;
      entry_t    e;
      bit        live;
      exp_rsp  = '0;
      e.kind   = r.cmd_kind;
      e.value  = r.cmd_value;
      e.source = r.cmd_source;
      live     = 1'b0;
      case (r.req_type)
        REQ_PUSH: exp_rsp.accepted = store_cmd(e);
        REQ_POP: begin
          if (rd_idx != wr_idx) begin
            exp_rsp.pop_valid  = 1'b1;
            exp_rsp.pop_kind   = slots[rd_idx].kind;
            exp_rsp.pop_value  = slots[rd_idx].value;
            exp_rsp.pop_source = slots[rd_idx].source;
            rd_idx = (rd_idx + 1) % QUEUE_SIZE;
          end
        end
        REQ_BATCH: begin
          if (r.batch_first) begin
            if (r.batch_count == 8'd0) begin
              batch_left = '0;
              batch_ok   = 1'b0;
            end else begin
              // admission decided once, on the room at the first element
              batch_ok   = (r.batch_count <= free_room());
              batch_left = r.batch_count;
              live       = 1'b1;
            end
          end else if (batch_left != 8'd0) begin
            live = 1'b1;
          end
          if (live) begin
            batch_left = batch_left - 8'd1;
            if (batch_ok) exp_rsp.accepted = store_cmd(e);
            else count_drop(e.source);
            if (batch_left == 8'd0) batch_ok = 1'b0;
          end
        end
        default: ;  // unused code leaves everything alone
      endcase
      exp_rsp.free_slots   = 4'(free_room());
      exp_rsp.drops_button = drop_button;
      exp_rsp.drops_mqtt   = drop_mqtt;
      exp_rsp.drops_web    = drop_web;
      awaited_rsp.push_back(exp_rsp);
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task check_response(rsp_item_t got);
      rsp_item_t e;
      if (awaited_rsp.size() == 0) begin
        report_mismatch("response beat with nothing awaited");
        return;
      end
      e = awaited_rsp.pop_front();
      if (got.accepted !== e.accepted)
        report_mismatch($sformatf("accepted %b, want %b", got.accepted, e.accepted));
      if (got.pop_valid !== e.pop_valid)
        report_mismatch($sformatf("pop_valid %b, want %b", got.pop_valid, e.pop_valid));
      if (got.pop_kind !== e.pop_kind)
        report_mismatch($sformatf("pop_kind %h, want %h", got.pop_kind, e.pop_kind));
      if (got.pop_value !== e.pop_value)
        report_mismatch($sformatf("pop_value %h, want %h", got.pop_value, e.pop_value));
      if (got.pop_source !== e.pop_source)
        report_mismatch($sformatf("pop_source %h, want %h", got.pop_source, e.pop_source));
      if (got.free_slots !== e.free_slots)
        report_mismatch($sformatf("free_slots %0d, want %0d", got.free_slots, e.free_slots));
      if (got.drops_button !== e.drops_button)
        report_mismatch($sformatf("drops_button %h, want %h", got.drops_button,
                                  e.drops_button));
      if (got.drops_mqtt !== e.drops_mqtt)
        report_mismatch($sformatf("drops_mqtt %h, want %h", got.drops_mqtt, e.drops_mqtt));
      if (got.drops_web !== e.drops_web)
        report_mismatch($sformatf("drops_web %h, want %h", got.drops_web, e.drops_web));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and the block
  // --------------------------------------------------------------------------
  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  req_item_t req       = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  rsp_item_t rsp;

  logic      calm          = 1'b0;  // no idling on either side while set
  int        hold_requests = 0;     // bumped by the sender to ask for a hold-off
  int        holds_served  = 0;
  int        hold_left     = 0;
  int        beats_sent    = 0;

  ring_queue_scoreboard sb;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  command_ring_queue_with_drop_counts i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // --------------------------------------------------------------------------
  // receiver: random back-pressure, plus a long hold-off on request
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (holds_served != hold_requests) begin
      // start of a long hold-off, counted here
      holds_served <= hold_requests;
      hold_left    <= HOLD_CYCLES;
      rsp_ready    <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= calm || ($urandom_range(0, 99) >= 7);
    end
  end

  // response monitor: every response beat is checked against the oldest prediction
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) sb.check_response(rsp);
  end

  // watchdog: ends the run when nothing moves for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // --------------------------------------------------------------------------
  // sender tasks
  // --------------------------------------------------------------------------
  function automatic req_item_t random_item();
    req_item_t r;
    r.req_type    = 2'($urandom_range(0, 3));
    r.cmd_kind    = 8'($urandom);
    r.cmd_value   = $urandom;
    r.cmd_source  = 2'($urandom_range(0, 3));
    r.batch_first = 1'($urandom_range(0, 1));
    r.batch_count = 8'($urandom);
    return r;
  endfunction

  function automatic req_item_t make_item(logic [1:0] rt, logic [7:0] kind, logic [31:0] value,
                                          logic [1:0] src, logic first, logic [7:0] count);
    req_item_t r;
    r.req_type    = rt;
    r.cmd_kind    = kind;
    r.cmd_value   = value;
    r.cmd_source  = src;
    r.batch_first = first;
    r.batch_count = count;
    return r;
  endfunction

  // one request beat; an optional one-cycle gap first, then valid held until taken
  task automatic drive_req(input req_item_t item);
    if (!calm && $urandom_range(0, 99) < 7) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req       <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    sb.note_request(item);
    beats_sent++;
  endtask

  task automatic send_push();
    req_item_t r;
    r = random_item();
    r.req_type = REQ_PUSH;
    drive_req(r);
  endtask

  task automatic send_pop();
    req_item_t r;
    r = random_item();
    r.req_type = REQ_POP;
    drive_req(r);
  endtask

  // first element carries len; elems batch beats in all, which may fall short of
  // len (abandoned) or run past it (stray followers)
  task automatic send_batch(int unsigned len, int unsigned elems, bit interleave);
    req_item_t r;
    r = random_item();
    r.req_type    = REQ_BATCH;
    r.batch_first = 1'b1;
    r.batch_count = 8'(len);
    drive_req(r);
    for (int unsigned i = 1; i < elems; i++) begin
      if (interleave && $urandom_range(0, 99) < 25) begin
        if ($urandom_range(0, 2) != 0) send_push();
        else send_pop();
      end
      r = random_item();
      r.req_type    = REQ_BATCH;
      r.batch_first = 1'b0;
      drive_req(r);
    end
  endtask

  // sender stops until every predicted response has come back
  task automatic wait_drained();
    req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned pick;
    int unsigned len;
    int unsigned elems;
    bit          filling;
    bit          hold_fired;
    bit          drain_fired;
    req_item_t   r;

    sb          = new();
    hold_fired  = 1'b0;
    drain_fired = 1'b0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed part
    drive_req(make_item(REQ_POP, 8'h00, 32'h0, SRC_BUTTON, 1'b0, 8'h00));   // pop when empty
    drive_req(make_item(REQ_PUSH, 8'h00, 32'h0, SRC_BUTTON, 1'b0, 8'h00));  // all-zero command
    drive_req(make_item(REQ_PUSH, 8'hff, 32'hffff_ffff, SRC_OTHER, 1'b1, 8'hff));
    r = random_item();
    r.req_type = REQ_NONE;                                                  // unused code
    drive_req(r);
    send_pop();
    send_pop();
    send_pop();                                                             // empty again
    drive_req(make_item(REQ_BATCH, 8'h11, 32'h1, SRC_MQTT, 1'b0, 8'h05));   // stray element
    drive_req(make_item(REQ_BATCH, 8'h22, 32'h2, SRC_WEB, 1'b1, 8'h00));    // empty batch
    drive_req(make_item(REQ_BATCH, 8'h31, 32'h31, SRC_BUTTON, 1'b1, 8'h03));
    drive_req(make_item(REQ_BATCH, 8'h32, 32'h32, SRC_MQTT, 1'b0, 8'h00));
    drive_req(make_item(REQ_BATCH, 8'h33, 32'h33, SRC_WEB, 1'b0, 8'h00));
    // batch too long for the room: each element refused, counted unless from the other source
    drive_req(make_item(REQ_BATCH, 8'h41, 32'h41, SRC_MQTT, 1'b1, 8'hff));
    drive_req(make_item(REQ_BATCH, 8'h42, 32'h42, SRC_WEB, 1'b0, 8'h00));
    drive_req(make_item(REQ_BATCH, 8'h43, 32'h43, SRC_OTHER, 1'b0, 8'h00));
    // new first element abandons the refused batch
    drive_req(make_item(REQ_BATCH, 8'h51, 32'h51, SRC_BUTTON, 1'b1, 8'h02));
    drive_req(make_item(REQ_BATCH, 8'h52, 32'h52, SRC_OTHER, 1'b0, 8'h00));
    send_pop();
    send_pop();
    // admitted batch sized to the exact room, with pushes and pops slipped in between
    send_batch(sb.free_room(), sb.free_room(), 1'b1);

    // random part
    while (beats_sent < RANDOM_BEATS + 25) begin
      if (!hold_fired && beats_sent >= 120) begin
        // long receiver hold-off while the sender keeps pushing
        hold_fired = 1'b1;
        hold_requests <= hold_requests + 1;
        repeat (24) send_push();
      end
      if (!drain_fired && beats_sent >= 340) begin
        drain_fired = 1'b1;
        wait_drained();
      end
      calm <= (beats_sent >= 200 && beats_sent < 300);

      filling = ((beats_sent / 90) % 2) == 0;
      pick    = $urandom_range(0, 99);
      if (pick < (filling ? 35 : 15)) begin
        send_push();
      end else if (pick < (filling ? 50 : 55)) begin
        send_pop();
      end else if (pick < 70) begin
        if ($urandom_range(0, 99) < 15) begin
          len   = $urandom_range(7, 255);
          elems = $urandom_range(1, 4);
        end else begin
          len   = $urandom_range(1, 6);
          elems = len;
          if ($urandom_range(0, 99) < 10) elems = $urandom_range(1, len);
          else if ($urandom_range(0, 99) < 10) elems = len + 1;
        end
        send_batch(len, elems, 1'b1);
      end else if (pick < (filling ? 85 : 80)) begin
        len = sb.free_room();
        if (len == 0) len = 1;
        send_batch(len, len, 1'b1);
      end else begin
        drive_req(random_item());
      end
    end

    // drain and let the last beat settle
    req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
